>>> sv/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies; each macro wraps one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/vlcp_pkg.sv
// Shared types, constants and helpers of the variable-length code packer.
// No dependencies; used by every module of the block.
`default_nettype none

package vlcp_pkg;

    localparam int WORD_BITS   = 32;
    localparam int CODE_BITS   = 32;
    localparam int TABLE_DEPTH = 256;
    localparam int SYM_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 6;
    localparam int OUT_BITS_W  = 6;
    localparam int MAX_LEN     = (WORD_BITS < CODE_BITS) ? WORD_BITS : CODE_BITS;
    localparam int FILL_W      = $clog2(WORD_BITS);
    localparam int SUM_W       = $clog2(2 * WORD_BITS) + 1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Registered table lookup for the packing stage
    typedef struct packed {
        logic                 hit;
        logic [LEN_W-1:0]     len;
        logic [CODE_BITS-1:0] code;
    } lookup_t;

    // Item held between the lookup and the packing stage
    typedef struct packed {
        logic valid;
        op_t  op;
    } slot_t;

    // Clamp a code length to what a word and a code can hold
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
        return res;
    endfunction

    // Keep only the low len bits of a code
    function automatic logic [CODE_BITS-1:0] mask_code(input logic [CODE_BITS-1:0] code,
                                                       input logic [LEN_W-1:0]     len);
        logic [CODE_BITS-1:0] msk;
        if (len >= LEN_W'(CODE_BITS))
            msk = '1;
        else
            msk = ~({CODE_BITS{1'b1}} << len);
        return code & msk;
    endfunction

endpackage

`default_nettype wire

>>> sv/variable_length_code_packer.sv
// Top level of the variable-length code packer: lookup stage and packing stage.
// Depends on vlcp_pkg, vlcp_code_table and vlcp_pack_stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: operation, symbol,
//   code_value, code_length. A load item writes one code table entry and
//   gives no result. An encode item looks up its symbol and appends the code
//   MSB-first to a 32-bit word; a result appears when the word fills, or
//   with missing_symbol set when the symbol has no entry. A flush item
//   always gives one result with last set and the partial bit count.
//   Output channel (out_valid/out_ready) carries packed_word, valid_bits,
//   missing_symbol and last.
//   Path: the table read registers when its item is accepted; the shift
//   and merge then load the result into the output register once that
//   register is free or being read.
//   Throughput: one item per cycle, set by the single-port table read,
//   while no result is stalled at the output. Reset clears all table entry
//   marks, the accumulator and the fill count; the table is usable right
//   after reset. When the receiver stalls, the result holds in the output
//   register; items that give no result keep flowing, and the input stalls only behind a result that cannot leave.
`default_nettype none

module variable_length_code_packer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       operation,
    input  wire logic [7:0]                       symbol,
    input  wire logic [31:0]                      code_value,
    input  wire logic [5:0]                       code_length,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [31:0]                           packed_word,
    output logic [5:0]                            valid_bits,
    output logic                                  missing_symbol,
    output logic                                  last
);

    logic              accept;
    logic              advance;
    vlcp_pkg::op_t     in_op;
    logic              s1_valid_reg, s1_valid_next;
    vlcp_pkg::op_t     s1_op_reg;
    vlcp_pkg::slot_t   slot;
    vlcp_pkg::lookup_t lookup;

    assign in_op    = vlcp_pkg::op_t'(operation);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // Table: write on a load, read on an encode
    vlcp_code_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (in_op == vlcp_pkg::OP_LOAD)),
        .rd_en   (accept && (in_op == vlcp_pkg::OP_ENCODE)),
        .addr    (symbol),
        .wr_code (code_value),
        .wr_len  (code_length),
        .lookup  (lookup)
    );

    // Track the item waiting on its lookup
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= vlcp_pkg::OP_NONE;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_op_reg <= in_op;
            end
        end
    end

    assign slot.valid = s1_valid_reg;
    assign slot.op    = s1_op_reg;

    // Shift, merge and emit
    vlcp_pack_stage u_pack (
        .clk            (clk),
        .rst_n          (rst_n),
        .slot           (slot),
        .lookup         (lookup),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .packed_word    (packed_word),
        .valid_bits     (valid_bits),
        .missing_symbol (missing_symbol),
        .last           (last)
    );

endmodule

`default_nettype wire

>>> sv/vlcp_code_table.sv
// Code table: one synchronous memory of code and length plus per-entry valid bits.
// Depends on vlcp_pkg.
`default_nettype none

module vlcp_code_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic                           rd_en,
    input  wire logic [vlcp_pkg::SYM_W-1:0]     addr,
    input  wire logic [vlcp_pkg::CODE_BITS-1:0] wr_code,
    input  wire logic [vlcp_pkg::LEN_W-1:0]     wr_len,
    output vlcp_pkg::lookup_t                   lookup
);

    localparam int ENTRY_W = vlcp_pkg::LEN_W + vlcp_pkg::CODE_BITS;

    logic [ENTRY_W-1:0]              entry_mem [vlcp_pkg::TABLE_DEPTH];
    logic [vlcp_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [ENTRY_W-1:0]              rd_entry_reg;
    logic                            rd_hit_reg;
    logic [vlcp_pkg::LEN_W-1:0]      len_sat;

    // Clamp the length and trim the code before storing
    assign len_sat = vlcp_pkg::sat_len(wr_len);

    // Write the entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[addr] <= {len_sat, vlcp_pkg::mask_code(wr_code, len_sat)};
        end
    end

    // Read the entry memory, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[addr];
        end
    end

    // Mark written entries; capture the mark on a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[addr];
            end
        end
    end

    assign lookup.hit  = rd_hit_reg;
    assign lookup.len  = rd_entry_reg[ENTRY_W-1 -: vlcp_pkg::LEN_W];
    assign lookup.code = rd_entry_reg[vlcp_pkg::CODE_BITS-1:0];

endmodule

`default_nettype wire

>>> sv/vlcp_pack_stage.sv
// Packing stage: accumulator, fill count and the output register.
// Depends on vlcp_pkg.
`default_nettype none

module vlcp_pack_stage (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire vlcp_pkg::slot_t                  slot,
    input  wire vlcp_pkg::lookup_t                lookup,
    output logic                                  advance,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [31:0]                           packed_word,
    output logic [vlcp_pkg::OUT_BITS_W-1:0]       valid_bits,
    output logic                                  missing_symbol,
    output logic                                  last
);

    localparam int WB = vlcp_pkg::WORD_BITS;

    logic [WB-1:0]                  acc_reg, acc_next;
    logic [vlcp_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic                           out_valid_reg, out_valid_next;
    logic [31:0]                    word_reg, word_next;
    logic [vlcp_pkg::OUT_BITS_W-1:0] bits_reg, bits_next;
    logic                           miss_reg, miss_next;
    logic                           last_reg, last_next;

    logic [vlcp_pkg::SUM_W-1:0]     total;
    logic [vlcp_pkg::SUM_W-1:0]     shamt;
    logic [2*WB-1:0]                window;
    logic [WB-1:0]                  merged;
    logic                           fills;
    logic                           has_result;
    logic                           slot_free;

    // Place the code in a two-word window below the bits already held
    always_comb
    begin
        total  = vlcp_pkg::SUM_W'(fill_reg) + vlcp_pkg::SUM_W'(lookup.len);
        shamt  = vlcp_pkg::SUM_W'(2 * WB) - total;
        window = {{WB{1'b0}}, WB'(lookup.code)} << shamt;
        merged = acc_reg | window[2*WB-1:WB];
        fills  = (total >= vlcp_pkg::SUM_W'(WB));
    end

    // Decide whether this item yields a result
    always_comb
    begin
        unique case (slot.op)
            vlcp_pkg::OP_ENCODE: has_result = !lookup.hit ||
                                              ((lookup.len != '0) && fills);
            vlcp_pkg::OP_FLUSH:  has_result = 1'b1;
            vlcp_pkg::OP_LOAD:   has_result = 1'b0;
            vlcp_pkg::OP_NONE:   has_result = 1'b0;
        endcase
    end

    // Advance when the output slot is free or nothing has to go out
    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = slot.valid && (slot_free || !has_result);

    // Next accumulator, fill count and output register
    always_comb
    begin
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        word_next      = word_reg;
        bits_next      = bits_reg;
        miss_next      = miss_reg;
        last_next      = last_reg;
        if (advance)
        begin
            unique case (slot.op)
                vlcp_pkg::OP_ENCODE:
                begin
                    if (!lookup.hit)
                    begin
                        word_next = '0;
                        bits_next = '0;
                        miss_next = 1'b1;
                        last_next = 1'b0;
                    end
                    else if (lookup.len != '0)
                    begin
                        if (fills)
                        begin
                            acc_next  = window[WB-1:0];
                            fill_next = vlcp_pkg::FILL_W'(total - vlcp_pkg::SUM_W'(WB));
                            word_next = 32'(merged);
                            bits_next = vlcp_pkg::OUT_BITS_W'(WB);
                            miss_next = 1'b0;
                            last_next = 1'b0;
                        end
                        else
                        begin
                            acc_next  = merged;
                            fill_next = vlcp_pkg::FILL_W'(total);
                        end
                    end
                end
                vlcp_pkg::OP_FLUSH:
                begin
                    word_next = 32'(acc_reg);
                    bits_next = vlcp_pkg::OUT_BITS_W'(fill_reg);
                    miss_next = 1'b0;
                    last_next = 1'b1;
                    acc_next  = '0;
                    fill_next = '0;
                end
                vlcp_pkg::OP_LOAD:
                begin
                end
                vlcp_pkg::OP_NONE:
                begin
                end
            endcase
            if (has_result)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        bits_reg <= bits_next;
        miss_reg <= miss_next;
        last_reg <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign packed_word    = word_reg;
    assign valid_bits     = bits_reg;
    assign missing_symbol = miss_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

>>> sv/vlcp_checker.sv
// Port-level checks on the result channel of the code packer, bound to the top.
// Depends on vlcp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vlcp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] packed_word,
    input wire logic [5:0]  valid_bits,
    input wire logic        missing_symbol,
    input wire logic        last
);

    // A stalled result stays and keeps its word
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(packed_word))

    // A missing-symbol result carries no bits and is not a flush
    `ASSERT_IMPLY(a_miss_empty, clk, rst_n, out_valid && missing_symbol, (packed_word == 32'd0) && (valid_bits == 6'd0) && !last)

    // A word result is always a full word
    `ASSERT_IMPLY(a_full_word, clk, rst_n, out_valid && !missing_symbol && !last, valid_bits == 6'(vlcp_pkg::WORD_BITS))

    // A flush never reports a full word
    `ASSERT_IMPLY(a_flush_partial, clk, rst_n, out_valid && last, valid_bits < 6'(vlcp_pkg::WORD_BITS))

endmodule

bind variable_length_code_packer vlcp_checker u_vlcp_checker (.*);

`default_nettype wire
